// ===== rtl/gwg3d_pkg.sv =====
// Shared constants and word types for the GIMP 3D weight and gradient block.
package gwg3d_pkg;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } offset_word_t;

    typedef struct packed {
        logic        [16:0] weight_product;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
    } result_word_t;

endpackage

// ===== rtl/gimp_weight_and_gradient_3d.sv =====
// GIMP 3D shape function: axis weights, weight product and gradient, fully pipelined.
//
// Usage
//   Offset channel: offset_valid / offset_stall / offset_word carries one particle-minus-node
//   offset (signed Q16.16 per axis). A word is taken at a rising edge with valid high and
//   stall low.
//   Result channel: result_valid / result_stall / result_word gives the weight product
//   (Q16.16, 0..1) and the three saturated gradient components, one result per offset.
//   APB port: six writable/readable 31-bit registers at byte address 4*i: cell sizes x/y/z,
//   then particle half-sizes x/y/z. A write of zero stores one. pready is tied high.
//   The user must write registers only while the block holds no work; the block itself does not enforce this.
// Timing
//   From acceptance to result_valid a word passes three front stages (absolute value
//   and zone, products, divider setup), 33 restoring-divider stages (one quotient bit per
//   stage, six dividers side by side), three back stages (weights, two product rows) and the
//   output register. One word enters per cycle while offset_stall is low.
// Reset
//   rst_n clears every valid bit and restores default register values; the pipe comes up empty.
// Stall
//   A skid register behind the pipe takes the word that arrives while the output register is
//   stalled; offset_stall then rises and the whole pipe holds until the skid drains.
module gimp_weight_and_gradient_3d (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     offset_valid,
    output logic                     offset_stall,
    input  gwg3d_pkg::offset_word_t  offset_word,
    output logic                     result_valid,
    input  logic                     result_stall,
    output gwg3d_pkg::result_word_t  result_word
);

    localparam int F   = gwg3d_pkg::FRAC_BITS;
    localparam int WF  = F + 1;          // axis weight width, 0..1
    localparam int QW  = 2 * F + 1;      // quotient bits per divider
    localparam int NS  = QW;             // divider stages
    localparam int G1W = QW + 1;         // gradient partial width
    localparam logic [WF-1:0] ONE = WF'(1) << F;

    localparam logic [2:0] REG_CELL_X = 3'd0;
    localparam logic [2:0] REG_CELL_Y = 3'd1;
    localparam logic [2:0] REG_CELL_Z = 3'd2;
    localparam logic [2:0] REG_HALF_X = 3'd3;
    localparam logic [2:0] REG_HALF_Y = 3'd4;
    localparam logic [2:0] REG_HALF_Z = 3'd5;

    typedef enum logic [1:0] {ZN_INNER, ZN_LINEAR, ZN_OUTER, ZN_BEYOND} zone_t;

    typedef struct packed {
        zone_t [2:0] zone;
        logic  [2:0] xneg;
        logic  [2:0] inzero;
    } side_t;

    // ---------------- configuration ----------------
    logic [30:0] cell_reg [3];
    logic [30:0] half_reg [3];
    logic [30:0] wval;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wval   = (pwdata[30:0] == 31'd0) ? 31'd1 : pwdata[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= 31'd65536;
                half_reg[a] <= 31'd16384;
            end
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_CELL_X: cell_reg[0] <= wval;
                REG_CELL_Y: cell_reg[1] <= wval;
                REG_CELL_Z: cell_reg[2] <= wval;
                REG_HALF_X: half_reg[0] <= wval;
                REG_HALF_Y: half_reg[1] <= wval;
                REG_HALF_Z: half_reg[2] <= wval;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CELL_X: prdata = {1'b0, cell_reg[0]};
            REG_CELL_Y: prdata = {1'b0, cell_reg[1]};
            REG_CELL_Z: prdata = {1'b0, cell_reg[2]};
            REG_HALF_X: prdata = {1'b0, half_reg[0]};
            REG_HALF_Y: prdata = {1'b0, half_reg[1]};
            REG_HALF_Z: prdata = {1'b0, half_reg[2]};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic                    skid_v_reg;
    gwg3d_pkg::result_word_t skid_reg;
    logic                    out_v_reg;
    gwg3d_pkg::result_word_t out_reg;
    logic                    en;

    assign en           = ~skid_v_reg;
    assign offset_stall = skid_v_reg;
    assign result_valid = out_v_reg;
    assign result_word  = out_reg;

    // ---------------- stage A: magnitude and zone ----------------
    logic [31:0] off_c [3];
    logic [31:0] a_r_next [3];
    logic [31:0] a_m_next [3];
    zone_t       a_zone_next [3];
    logic        a_v_reg;
    logic [31:0] a_r_reg [3];
    logic [31:0] a_m_reg [3];
    logic [30:0] a_h_reg [3];
    logic [30:0] a_l_reg [3];
    logic        a_xneg_reg [3];
    zone_t       a_zone_reg [3];

    always_comb
    begin
        logic [31:0] sum;
        off_c[0] = offset_word.offset_x;
        off_c[1] = offset_word.offset_y;
        off_c[2] = offset_word.offset_z;
        for (int a = 0; a < 3; a++)
        begin
            a_r_next[a] = off_c[a][31] ? (32'd0 - off_c[a]) : off_c[a];
            sum = {1'b0, cell_reg[a]} + {1'b0, half_reg[a]};
            a_m_next[a] = sum - a_r_next[a];
            if (a_r_next[a] < {1'b0, half_reg[a]})
                a_zone_next[a] = ZN_INNER;
            else if ($signed({2'b00, a_r_next[a]}) <
                     ($signed({3'b000, cell_reg[a]}) - $signed({3'b000, half_reg[a]})))
                a_zone_next[a] = ZN_LINEAR;
            else if (a_r_next[a] < sum)
                a_zone_next[a] = ZN_OUTER;
            else
                a_zone_next[a] = ZN_BEYOND;
        end
    end

    // ---------------- stage B: products ----------------
    logic        b_v_reg;
    logic [63:0] b_rr_reg [3];
    logic [63:0] b_ll_reg [3];
    logic [63:0] b_hl_reg [3];
    logic [63:0] b_mm_reg [3];
    logic [31:0] b_r_reg [3];
    logic [31:0] b_m_reg [3];
    logic [30:0] b_h_reg [3];
    logic        b_xneg_reg [3];
    zone_t       b_zone_reg [3];

    // ---------------- stage C and divider pipe ----------------
    // lanes 0..2: weight quotients, lanes 3..5: slope quotients
    logic [63:0] c_num_next [6];
    logic [63:0] c_den_next [6];
    side_t       c_side_next;

    logic        dv_v_reg    [NS+1];
    side_t       dv_side_reg [NS+1];
    logic [63:0] dv_rem_reg  [NS+1][6];
    logic [63:0] dv_den_reg  [NS+1][6];
    logic [QW-1:0] dv_q_reg  [NS+1][6];

    logic [63:0]   dv_rem_next [NS][6];
    logic [QW-1:0] dv_q_next   [NS][6];

    always_comb
    begin
        logic [64:0] n;
        logic [63:0] d2;
        logic [63:0] d4;
        for (int a = 0; a < 3; a++)
        begin
            n  = {1'b0, b_rr_reg[a]} + {1'b0, b_ll_reg[a]};
            d2 = {b_hl_reg[a][62:0], 1'b0};
            d4 = {b_hl_reg[a][61:0], 2'b00};
            c_side_next.zone[a]   = b_zone_reg[a];
            c_side_next.xneg[a]   = b_xneg_reg[a];
            c_side_next.inzero[a] = (n >= {1'b0, d2});
            unique case (b_zone_reg[a])
                ZN_INNER:
                begin
                    c_num_next[a]   = c_side_next.inzero[a] ? 64'd0 : n[63:0];
                    c_den_next[a]   = d2;
                    c_num_next[a+3] = {32'd0, b_r_reg[a]};
                    c_den_next[a+3] = d2;
                end
                ZN_LINEAR:
                begin
                    c_num_next[a]   = {32'd0, b_r_reg[a]};
                    c_den_next[a]   = {33'd0, b_h_reg[a]};
                    c_num_next[a+3] = 64'd1;
                    c_den_next[a+3] = {32'd0, b_h_reg[a], 1'b0};
                end
                ZN_OUTER:
                begin
                    c_num_next[a]   = b_mm_reg[a];
                    c_den_next[a]   = d4;
                    c_num_next[a+3] = {32'd0, b_m_reg[a]};
                    c_den_next[a+3] = d4;
                end
                default:
                begin
                    c_num_next[a]   = 64'd0;
                    c_den_next[a]   = 64'd1;
                    c_num_next[a+3] = 64'd0;
                    c_den_next[a+3] = 64'd1;
                end
            endcase
        end
    end

    // one restoring step per stage; the dividend's low bits are zeros
    always_comb
    begin
        logic [64:0] t;
        logic        ge;
        for (int k = 0; k < NS; k++)
        begin
            for (int ln = 0; ln < 6; ln++)
            begin
                t  = {dv_rem_reg[k][ln], 1'b0};
                ge = (t >= {1'b0, dv_den_reg[k][ln]});
                dv_rem_next[k][ln] = ge ? 64'(t - {1'b0, dv_den_reg[k][ln]}) : t[63:0];
                dv_q_next[k][ln]   = {dv_q_reg[k][ln][QW-2:0], ge};
            end
        end
    end

    // ---------------- back stages ----------------
    logic [WF-1:0] p1_w_next [3];
    logic [QW-1:0] p1_mag_next [3];
    logic          p1_v_reg;
    logic [WF-1:0] p1_w_reg [3];
    logic [QW-1:0] p1_mag_reg [3];
    logic          p1_neg_reg [3];

    logic            p2_v_reg;
    logic [2*WF-1:0] p2_wxy_reg;
    logic [G1W-1:0]  p2_g1_reg [3];
    logic [WF-1:0]   p2_wb_reg [3];
    logic [WF-1:0]   p2_wz_reg;
    logic            p2_neg_reg [3];

    logic            p3_v_reg;
    logic [WF:0]     p3_wp_reg;
    logic [G1W-1:0]  p3_g2_reg [3];
    logic            p3_neg_reg [3];

    always_comb
    begin
        logic [F-1:0] wq;
        for (int a = 0; a < 3; a++)
        begin
            wq = dv_q_reg[NS][a][QW-1:F+1];
            p1_mag_next[a] = dv_q_reg[NS][a+3];
            unique case (dv_side_reg[NS].zone[a])
                ZN_INNER:  p1_w_next[a] = dv_side_reg[NS].inzero[a] ? '0 : ONE - {1'b0, wq};
                ZN_LINEAR: p1_w_next[a] = ONE - {1'b0, wq};
                ZN_OUTER:  p1_w_next[a] = {1'b0, wq};
                default:
                begin
                    p1_w_next[a]   = '0;
                    p1_mag_next[a] = '0;
                end
            endcase
        end
    end

    // other-axis weights, in axis order
    function automatic int other_a(input int a);
        return (a == 0) ? 1 : 0;
    endfunction
    function automatic int other_b(input int a);
        return (a == 2) ? 1 : 2;
    endfunction

    logic [QW+WF-1:0]  g1_prod [3];
    logic [G1W+WF-1:0] g2_prod [3];
    logic [2*WF:0]     wp_prod;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            g1_prod[a] = {{WF{1'b0}}, p1_mag_reg[a]} *
                         {{QW{1'b0}}, p1_w_reg[other_a(a)]};
            g2_prod[a] = {{WF{1'b0}}, p2_g1_reg[a]} * {{G1W{1'b0}}, p2_wb_reg[a]};
        end
        wp_prod = {{WF{1'b0}}, p2_wxy_reg[2*WF-1:F]} * {{(WF+1){1'b0}}, p2_wz_reg};
    end

    // ---------------- output formatting ----------------
    gwg3d_pkg::result_word_t p_word;
    logic [31:0]             g_sat [3];

    always_comb
    begin
        logic [WF:0] wp;
        for (int a = 0; a < 3; a++)
        begin
            if (p3_neg_reg[a])
                g_sat[a] = (p3_g2_reg[a] >= G1W'(64'h8000_0000)) ? 32'h8000_0000
                                                                : 32'd0 - p3_g2_reg[a][31:0];
            else
                g_sat[a] = (p3_g2_reg[a] > G1W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                               : p3_g2_reg[a][31:0];
        end
        wp = (p3_wp_reg > {1'b0, ONE}) ? {1'b0, ONE} : p3_wp_reg;
        p_word.weight_product = 17'(wp);
        p_word.grad_x = g_sat[0];
        p_word.grad_y = g_sat[1];
        p_word.grad_z = g_sat[2];
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            for (int k = 0; k <= NS; k++)
                dv_v_reg[k] <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg     <= offset_valid;
            b_v_reg     <= a_v_reg;
            dv_v_reg[0] <= b_v_reg;
            for (int k = 0; k < NS; k++)
                dv_v_reg[k+1] <= dv_v_reg[k];
            p1_v_reg <= dv_v_reg[NS];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                a_r_reg[a]    <= a_r_next[a];
                a_m_reg[a]    <= a_m_next[a];
                a_h_reg[a]    <= cell_reg[a];
                a_l_reg[a]    <= half_reg[a];
                a_xneg_reg[a] <= off_c[a][31];
                a_zone_reg[a] <= a_zone_next[a];

                b_rr_reg[a]   <= {32'd0, a_r_reg[a]} * {32'd0, a_r_reg[a]};
                b_ll_reg[a]   <= {33'd0, a_l_reg[a]} * {33'd0, a_l_reg[a]};
                b_hl_reg[a]   <= {33'd0, a_h_reg[a]} * {33'd0, a_l_reg[a]};
                b_mm_reg[a]   <= {32'd0, a_m_reg[a]} * {32'd0, a_m_reg[a]};
                b_r_reg[a]    <= a_r_reg[a];
                b_m_reg[a]    <= a_m_reg[a];
                b_h_reg[a]    <= a_h_reg[a];
                b_xneg_reg[a] <= a_xneg_reg[a];
                b_zone_reg[a] <= a_zone_reg[a];
            end

            dv_side_reg[0] <= c_side_next;
            for (int ln = 0; ln < 6; ln++)
            begin
                dv_rem_reg[0][ln] <= c_num_next[ln];
                dv_den_reg[0][ln] <= c_den_next[ln];
                dv_q_reg[0][ln]   <= '0;
            end
            for (int k = 0; k < NS; k++)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                for (int ln = 0; ln < 6; ln++)
                begin
                    dv_rem_reg[k+1][ln] <= dv_rem_next[k][ln];
                    dv_den_reg[k+1][ln] <= dv_den_reg[k][ln];
                    dv_q_reg[k+1][ln]   <= dv_q_next[k][ln];
                end
            end

            for (int a = 0; a < 3; a++)
            begin
                p1_w_reg[a]   <= p1_w_next[a];
                p1_mag_reg[a] <= p1_mag_next[a];
                // slope sign is -sgn(x), positive for a zero slope
                p1_neg_reg[a] <= ~dv_side_reg[NS].xneg[a] && (p1_mag_next[a] != '0);

                p2_g1_reg[a]  <= g1_prod[a][QW+WF-1:F];
                p2_wb_reg[a]  <= p1_w_reg[other_b(a)];
                p2_neg_reg[a] <= p1_neg_reg[a];

                p3_g2_reg[a]  <= g2_prod[a][G1W+F-1:F];
                p3_neg_reg[a] <= p2_neg_reg[a];
            end
            p2_wxy_reg <= {{WF{1'b0}}, p1_w_reg[0]} * {{WF{1'b0}}, p1_w_reg[1]};
            p2_wz_reg  <= p1_w_reg[2];
            p3_wp_reg  <= wp_prod[2*WF-1:F];
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (!out_v_reg || !result_stall)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg || !result_stall)
            out_v_reg <= p3_v_reg;
        else if (p3_v_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (!out_v_reg || !result_stall)
                out_reg <= skid_reg;
        end
        else if (!out_v_reg || !result_stall)
            out_reg <= p_word;
        else if (p3_v_reg)
            skid_reg <= p_word;
    end

endmodule

// ===== verif/gimp_weight_and_gradient_3d_tb.sv =====
// Self-checking testbench for the GIMP 3D weight and gradient block.
module gimp_weight_and_gradient_3d_tb;

    localparam int          CLK_HALF   = 5;
    localparam int          DRAIN_WAIT = 60;     // lets the pipe run empty
    localparam int          IDLE_LIMIT = 3000;   // cycles with no word accepted
    localparam int          FRAC_BITS  = gwg3d_pkg::FRAC_BITS;
    localparam logic [63:0] ONE        = 64'd1 << FRAC_BITS;

    // APB register indexes, byte address is 4*index
    localparam int REG_CELL_X  = 0;
    localparam int REG_CELL_Y  = 1;
    localparam int REG_CELL_Z  = 2;
    localparam int REG_HALF_X  = 3;
    localparam int REG_HALF_Y  = 4;
    localparam int REG_HALF_Z  = 5;
    localparam int REG_UNUSED  = 6;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [4:0]              paddr        = '0;
    logic [31:0]             pwdata       = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    offset_valid = 1'b0;
    logic                    offset_stall;
    gwg3d_pkg::offset_word_t offset_word  = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    gwg3d_pkg::result_word_t result_word;

    gimp_weight_and_gradient_3d DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .offset_valid (offset_valid),
        .offset_stall (offset_stall),
        .offset_word  (offset_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Local copy of the register file, updated as each APB write is issued.
    logic [63:0]  cell_len [3];
    logic [63:0]  half_len [3];

    gwg3d_pkg::offset_word_t offset_queue[$];      // words waiting for the driver
    gwg3d_pkg::result_word_t expected_results[$];  // predicted results, oldest first
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           offset_taken = 1'b0;  // word accepted at the last rising edge
    bit           burst_mode   = 1'b0;  // stretch with no idling at all

    // ------------------------------------------------------------------
    // Shape function of one axis. Exact floored integer math in 128 bits,
    // wide enough that no intermediate product wraps.
    // ------------------------------------------------------------------
    function automatic void axis_shape(input logic [31:0] x, input logic [63:0] h,
                                       input logic [63:0] l,
                                       output logic [127:0] w, output logic [127:0] mag,
                                       output logic neg);
        logic [127:0] r;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] m;
        logic [127:0] hl;
        r   = x[31] ? (128'h1_0000_0000 - x) : x;
        hl  = h * l;
        neg = !x[31];   // slope sign is minus the sign of x, zero counts as positive
        if (r < l)
        begin
            // inner quadratic zone; weight may go negative and is then held at zero
            n   = r * r + l * l;
            d   = 2 * hl;
            w   = (n >= d) ? 128'd0 : ONE - ((n << FRAC_BITS) / d);
            mag = (r << (2 * FRAC_BITS)) / hl;
        end
        else if ((h > l) && (r < h - l))
        begin
            // linear zone, empty when the cell is no wider than the particle
            w   = ONE - ((r << FRAC_BITS) / h);
            mag = (128'd1 << (2 * FRAC_BITS)) / h;
        end
        else if (r < h + l)
        begin
            m   = h + l - r;
            w   = ((m * m) << (FRAC_BITS - 2)) / hl;
            mag = (m << (2 * FRAC_BITS - 1)) / hl;
        end
        else
        begin
            w   = '0;
            mag = '0;
        end
        if (w > ONE)
            w = ONE;
        if (mag == 0)
            neg = 1'b0;
    endfunction

    function automatic logic [31:0] grad_saturate(input logic [127:0] mag, input logic neg);
        if (neg)
            return (mag >= 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // slope magnitude times the two other weights, each product floored
    function automatic logic [127:0] scale_by_weights(input logic [127:0] mag,
                                                      input logic [127:0] wa,
                                                      input logic [127:0] wb);
        logic [127:0] t;
        t = (mag * wa) >> FRAC_BITS;
        return (t * wb) >> FRAC_BITS;
    endfunction

    function automatic gwg3d_pkg::result_word_t shape_result(
        input gwg3d_pkg::offset_word_t ow);
        gwg3d_pkg::result_word_t res;
        logic [127:0] w   [3];
        logic [127:0] mag [3];
        logic         neg [3];
        logic [127:0] wp;
        axis_shape(ow.offset_x, cell_len[0], half_len[0], w[0], mag[0], neg[0]);
        axis_shape(ow.offset_y, cell_len[1], half_len[1], w[1], mag[1], neg[1]);
        axis_shape(ow.offset_z, cell_len[2], half_len[2], w[2], mag[2], neg[2]);
        wp = (((w[0] * w[1]) >> FRAC_BITS) * w[2]) >> FRAC_BITS;
        if (wp > ONE)
            wp = ONE;
        res.weight_product = wp[16:0];
        res.grad_x = grad_saturate(scale_by_weights(mag[0], w[1], w[2]), neg[0]);
        res.grad_y = grad_saturate(scale_by_weights(mag[1], w[0], w[2]), neg[1]);
        res.grad_z = grad_saturate(scale_by_weights(mag[2], w[0], w[1]), neg[2]);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        if (burst_mode)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // ------------------------------------------------------------------
    // Offset driver: changes inputs at the falling edge, holds a stalled word.
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n && !(offset_valid && !offset_taken))
        begin
            if ($urandom_range(0, 199) == 0)
                burst_mode = !burst_mode;
            if (send_gap > 0)
            begin
                send_gap--;
                offset_valid <= 1'b0;
            end
            else if (offset_queue.size() > 0)
            begin
                offset_word  <= offset_queue.pop_front();
                offset_valid <= 1'b1;
                send_gap = idle_len();
            end
            else
                offset_valid <= 1'b0;
        end
    end

    // Result side back-pressure
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted offset, check each accepted result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        gwg3d_pkg::result_word_t want;
        bit           took_in;
        bit           took_out;
        took_in  = rst_n && offset_valid && !offset_stall;
        took_out = rst_n && result_valid && !result_stall;
        offset_taken = took_in;
        if (took_in)
            expected_results.push_back(shape_result(offset_word));
        if (took_out)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected: %h", $time, result_word);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_word.weight_product !== want.weight_product)
                begin
                    $display("%0t: weight_product expected %h actual %h", $time,
                             want.weight_product, result_word.weight_product);
                    error_count++;
                end
                if (result_word.grad_x !== want.grad_x)
                begin
                    $display("%0t: grad_x expected %h actual %h", $time,
                             want.grad_x, result_word.grad_x);
                    error_count++;
                end
                if (result_word.grad_y !== want.grad_y)
                begin
                    $display("%0t: grad_y expected %h actual %h", $time,
                             want.grad_y, result_word.grad_y);
                    error_count++;
                end
                if (result_word.grad_z !== want.grad_z)
                begin
                    $display("%0t: grad_z expected %h actual %h", $time,
                             want.grad_z, result_word.grad_z);
                    error_count++;
                end
            end
        end
        // watchdog on lack of progress
        if (took_in || took_out)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("** gimp_weight_and_gradient_3d: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic reg_write(input int index, input logic [31:0] value);
        logic [63:0] v;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(index * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // register holds 31 bits, a zero reads back as one; other indexes ignored
        v = {33'd0, value[30:0]};
        if (v == 0)
            v = 1;
        if (index <= REG_CELL_Z)
            cell_len[index] = v;
        else if (index <= REG_HALF_Z)
            half_len[index - REG_HALF_X] = v;
    endtask

    task automatic set_axes(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] hx,
                            input logic [31:0] hy, input logic [31:0] hz);
        reg_write(REG_CELL_X, cx);
        reg_write(REG_CELL_Y, cy);
        reg_write(REG_CELL_Z, cz);
        reg_write(REG_HALF_X, hx);
        reg_write(REG_HALF_Y, hy);
        reg_write(REG_HALF_Z, hz);
    endtask

    // Offset along one axis, aimed at the zones of the current setting.
    function automatic logic [31:0] pick_offset(input logic [63:0] h, input logic [63:0] l);
        logic [63:0] r;
        logic [63:0] span;
        logic [63:0] rnd;
        int          pick;
        rnd  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        case (pick)
            0: return $urandom;
            1: return 32'd0;
            2: r = rnd % l;
            3: r = l + rnd % h;
            4:
            begin
                case ($urandom_range(0, 5))
                    0: r = l - 1;
                    1: r = l;
                    2: r = (h > l) ? h - l - 1 : l;
                    3: r = (h > l) ? h - l : l;
                    4: r = h + l - 1;
                    default: r = h + l;
                endcase
            end
            5: r = h + l + rnd % (h + 1);
            default:
            begin
                span = h + l + 1;
                r    = rnd % span;
            end
        endcase
        if (r > 64'h8000_0000)
            r = 64'h8000_0000;
        if ($urandom_range(0, 1))
            return -r[31:0];
        return (r == 64'h8000_0000) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    task automatic queue_random(input int count);
        gwg3d_pkg::offset_word_t ow;
        repeat (count)
        begin
            ow.offset_x = pick_offset(cell_len[0], half_len[0]);
            ow.offset_y = pick_offset(cell_len[1], half_len[1]);
            ow.offset_z = pick_offset(cell_len[2], half_len[2]);
            offset_queue.push_back(ow);
        end
    endtask

    // Wait until every queued word has gone in and every result has come out,
    // then let the pipe run empty before touching the registers.
    task automatic drain();
        while (offset_queue.size() != 0 || offset_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_setting();
        logic [31:0] h [3];
        logic [31:0] l [3];
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                h[a] = $urandom;
                l[a] = $urandom;
            end
            else
            begin
                h[a] = $urandom_range(32'h100, 32'h40_0000);
                l[a] = $urandom_range(1, h[a]);
            end
        end
        set_axes(h[0], h[1], h[2], l[0], l[1], l[2]);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        gwg3d_pkg::offset_word_t ow;
        logic [31:0]  edge_vals [14];
        for (int a = 0; a < 3; a++)
        begin
            cell_len[a] = 64'd65536;
            half_len[a] = 64'd16384;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zone edges at the reset setting (h = 1.0, l = 0.25),
        // zero offset in the inner zone, and the extremes of the field.
        edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd16383, -32'd16383, 32'd16384,
                      32'd49151, 32'd49152, -32'd49152, 32'd81919, 32'd81920,
                      -32'd81920, 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (edge_vals[i])
        begin
            ow.offset_x = edge_vals[i];
            ow.offset_y = edge_vals[(i + 5) % 14];
            ow.offset_z = edge_vals[(i + 9) % 14];
            offset_queue.push_back(ow);
        end
        // z axis at the origin, x and y at opposite deep inner offsets
        ow = '{32'd8192, -32'd8192, 32'd0};
        offset_queue.push_back(ow);
        queue_random(60);
        drain();

        // Particle as wide as or wider than the cell: linear zone empty on y and z.
        set_axes(32'd65536, 32'd65536, 32'd65536, 32'd32768, 32'd65536, 32'd100000);
        queue_random(85);
        drain();

        // Extremes: smallest, largest, and zero writes that read as one;
        // writes to unused addresses must change nothing.
        set_axes(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0);
        reg_write(REG_UNUSED, 32'h1234_5678);
        reg_write(REG_UNUSED + 1, 32'hFFFF_FFFF);
        queue_random(85);
        drain();

        // Huge cells with tiny particles: slopes near zero, weights near one.
        set_axes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        queue_random(85);
        drain();

        // Tiny cells with particles wider than the cell: steep slopes.
        set_axes(32'd1, 32'd3, 32'd2, 32'h7FFF_FFFF, 32'h4000_0000, 32'd7);
        queue_random(85);
        drain();

        repeat (4)
        begin
            random_setting();
            queue_random(85);
            drain();
        end

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** gimp_weight_and_gradient_3d: PASSED **");
        else
            $display("** gimp_weight_and_gradient_3d: FAILED **");
        $finish;
    end

endmodule

// ===== gimp_weight_and_gradient_3d.f =====
rtl/gwg3d_pkg.sv
rtl/gimp_weight_and_gradient_3d.sv
verif/gimp_weight_and_gradient_3d_tb.sv
